### src/gkp_pkg.sv
// Types, constants and micro-program for the Gauss-Kruger local projection block.
`default_nettype none
package gkp_pkg;

    // Datapath word: wide enough for the Q30 series constants
    localparam int WORD_W   = 41;
    localparam int MUL_W    = 36;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = 5;
    localparam int PC_W     = 7;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [RF_AW-1:0]         t_raddr;
    typedef logic [PC_W-1:0]          t_pc;

    // Beat payloads
    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
    } t_in_beat;

    typedef struct packed {
        logic signed [35:0] north_offset;
        logic signed [35:0] west_offset;
    } t_out_beat;

    // Values prepared at acceptance and handed to the engine
    typedef struct packed {
        t_word      lat;
        t_word      red;
        t_word      dl;
        logic [1:0] quad;
    } t_prep;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MULT,
        ST_WB,
        ST_OUT
    } t_eng_state;

    // Micro-op fields
    typedef enum logic [1:0] {UK_MUL, UK_QSB, UK_QCB, UK_END} t_ukind;
    typedef enum logic [2:0] {CM_NONE, CM_ADD, CM_SUB, CM_RSUB, CM_DIV} t_cmode;
    typedef enum logic [1:0] {PO_NONE, PO_SHR6, PO_ABS} t_post;
    typedef enum logic {SH_29, SH_30} t_shift;
    typedef enum logic [2:0] {OK_MEM, OK_CON, OK_LAT, OK_RED, OK_DL} t_okind;

    typedef struct packed {
        t_okind     k;
        logic [5:0] i;
    } t_osel;

    typedef struct packed {
        t_ukind kind;
        t_osel  a;
        t_osel  b;
        t_osel  c;
        t_shift sh;
        t_cmode cm;
        t_post  po;
        t_raddr dst;
    } t_uop;

    // Register file map
    localparam t_raddr RG_A   = 5'd0;
    localparam t_raddr RG_X2  = 5'd1;
    localparam t_raddr RG_T   = 5'd2;
    localparam t_raddr RG_V   = 5'd3;
    localparam t_raddr RG_Q   = 5'd4;
    localparam t_raddr RG_S0  = 5'd5;
    localparam t_raddr RG_SB  = 5'd6;
    localparam t_raddr RG_CB  = 5'd7;
    localparam t_raddr RG_CB2 = 5'd8;
    localparam t_raddr RG_SC  = 5'd9;
    localparam t_raddr RG_L   = 5'd10;
    localparam t_raddr RG_L2  = 5'd11;
    localparam t_raddr RG_N10 = 5'd12;
    localparam t_raddr RG_A0  = 5'd13;
    localparam t_raddr RG_A3  = 5'd14;
    localparam t_raddr RG_A4  = 5'd15;
    localparam t_raddr RG_A5  = 5'd16;
    localparam t_raddr RG_A6  = 5'd17;
    localparam t_raddr RG_P   = 5'd18;
    localparam t_raddr RG_MER = 5'd19;
    localparam t_raddr RG_XO  = 5'd20;
    localparam t_raddr RG_YO  = 5'd21;

    // Constant table indexes
    localparam logic [5:0] CI_ONE   = 6'd0;
    localparam logic [5:0] CI_HALF  = 6'd1;
    localparam logic [5:0] CI_D2R   = 6'd2;
    localparam logic [5:0] CI_K16   = 6'd3;
    localparam logic [5:0] CI_MS0   = 6'd4;
    localparam logic [5:0] CI_MS1   = 6'd5;
    localparam logic [5:0] CI_MS2   = 6'd6;
    localparam logic [5:0] CI_MS3   = 6'd7;
    localparam logic [5:0] CI_MS4   = 6'd8;
    localparam logic [5:0] CI_DS0   = 6'd9;
    localparam logic [5:0] CI_DS1   = 6'd10;
    localparam logic [5:0] CI_DS2   = 6'd11;
    localparam logic [5:0] CI_DS3   = 6'd12;
    localparam logic [5:0] CI_DS4   = 6'd13;
    localparam logic [5:0] CI_MC0   = 6'd14;
    localparam logic [5:0] CI_MC1   = 6'd15;
    localparam logic [5:0] CI_MC2   = 6'd16;
    localparam logic [5:0] CI_MC3   = 6'd17;
    localparam logic [5:0] CI_MC4   = 6'd18;
    localparam logic [5:0] CI_MC5   = 6'd19;
    localparam logic [5:0] CI_DC0   = 6'd20;
    localparam logic [5:0] CI_DC1   = 6'd21;
    localparam logic [5:0] CI_DC2   = 6'd22;
    localparam logic [5:0] CI_DC3   = 6'd23;
    localparam logic [5:0] CI_DC4   = 6'd24;
    localparam logic [5:0] CI_DC5   = 6'd25;
    localparam logic [5:0] CI_N0    = 6'd26;
    localparam logic [5:0] CI_N1    = 6'd27;
    localparam logic [5:0] CI_N2    = 6'd28;
    localparam logic [5:0] CI_N3    = 6'd29;
    localparam logic [5:0] CI_B0    = 6'd30;
    localparam logic [5:0] CI_B1    = 6'd31;
    localparam logic [5:0] CI_B2    = 6'd32;
    localparam logic [5:0] CI_B3    = 6'd33;
    localparam logic [5:0] CI_A4A   = 6'd34;
    localparam logic [5:0] CI_A4B   = 6'd35;
    localparam logic [5:0] CI_A4C   = 6'd36;
    localparam logic [5:0] CI_A6A   = 6'd37;
    localparam logic [5:0] CI_A6B   = 6'd38;
    localparam logic [5:0] CI_A3A   = 6'd39;
    localparam logic [5:0] CI_A3B   = 6'd40;
    localparam logic [5:0] CI_A3C   = 6'd41;
    localparam logic [5:0] CI_A5A   = 6'd42;
    localparam logic [5:0] CI_A5B   = 6'd43;
    localparam logic [5:0] CI_A5C   = 6'd44;
    localparam logic [5:0] CI_A5D   = 6'd45;

    localparam t_word ONE_Q30 = 41'sd1073741824;
    localparam t_pc   PC_END  = 7'd69;

    // Series and reciprocal constants; M = floor(2^30 / d) for the Taylor divisors
    function automatic t_word con_val(input logic [5:0] idx);
        t_word v;
        unique case (idx)
            CI_ONE:  v = 41'sd1073741824;
            CI_HALF: v = 41'sd536870912;
            CI_D2R:  v = 41'sd1199381129;
            CI_K16:  v = 41'sd7283334256;
            CI_MS0:  v = 41'sd9761289;
            CI_MS1:  v = 41'sd14913080;
            CI_MS2:  v = 41'sd25565281;
            CI_MS3:  v = 41'sd53687091;
            CI_MS4:  v = 41'sd178956970;
            CI_DS0:  v = 41'sd110;
            CI_DS1:  v = 41'sd72;
            CI_DS2:  v = 41'sd42;
            CI_DS3:  v = 41'sd20;
            CI_DS4:  v = 41'sd6;
            CI_MC0:  v = 41'sd8134407;
            CI_MC1:  v = 41'sd11930464;
            CI_MC2:  v = 41'sd19173961;
            CI_MC3:  v = 41'sd35791394;
            CI_MC4:  v = 41'sd89478485;
            CI_MC5:  v = 41'sd536870912;
            CI_DC0:  v = 41'sd132;
            CI_DC1:  v = 41'sd90;
            CI_DC2:  v = 41'sd56;
            CI_DC3:  v = 41'sd30;
            CI_DC4:  v = 41'sd12;
            CI_DC5:  v = 41'sd2;
            CI_N0:   v = 41'sd419410667241;
            CI_N1:   v = 41'sd1413104730;
            CI_N2:   v = 41'sd7141655;
            CI_N3:   v = 41'sd40108;
            CI_B0:   v = 41'sd2106353517;
            CI_B1:   v = 41'sd8869000;
            CI_B2:   v = 41'sd46478;
            CI_B3:   v = 41'sd262;
            CI_A4A:  v = 41'sd268435456;
            CI_A4B:  v = 41'sd2705829;
            CI_A4C:  v = 41'sd44732084;
            CI_A6A:  v = 41'sd178241143;
            CI_A6B:  v = 41'sd90194313;
            CI_A3A:  v = 41'sd357913906;
            CI_A3B:  v = 41'sd1205812;
            CI_A3C:  v = 41'sd178957006;
            CI_A5A:  v = 41'sd8912057;
            CI_A5B:  v = 41'sd178992762;
            CI_A5C:  v = 41'sd211312391;
            CI_A5D:  v = 41'sd4294967;
            default: v = '0;
        endcase
        return v;
    endfunction

    localparam t_osel O_LAT  = '{k: OK_LAT, i: 6'd0};
    localparam t_osel O_RED  = '{k: OK_RED, i: 6'd0};
    localparam t_osel O_DL   = '{k: OK_DL,  i: 6'd0};
    localparam t_osel O_NONE = '{k: OK_CON, i: CI_ONE};

    function automatic t_osel mr(input t_raddr r);
        t_osel s;
        s.k = OK_MEM;
        s.i = {1'b0, r};
        return s;
    endfunction

    function automatic t_osel cn(input logic [5:0] c);
        t_osel s;
        s.k = OK_CON;
        s.i = c;
        return s;
    endfunction

    function automatic t_uop u_mul(input t_osel a, input t_osel b, input t_osel c,
                                   input t_shift sh, input t_cmode cm, input t_post po,
                                   input t_raddr dst);
        t_uop u;
        u.kind = UK_MUL;
        u.a    = a;
        u.b    = b;
        u.c    = c;
        u.sh   = sh;
        u.cm   = cm;
        u.po   = po;
        u.dst  = dst;
        return u;
    endfunction

    function automatic t_uop u_ctl(input t_ukind kind, input t_raddr dst);
        t_uop u;
        u      = u_mul(mr(RG_S0), mr(RG_T), O_NONE, SH_30, CM_NONE, PO_NONE, dst);
        u.kind = kind;
        return u;
    endfunction

    // Shorthands for the common product forms
    function automatic t_uop mq(input t_osel a, input t_osel b, input t_raddr dst);
        return u_mul(a, b, O_NONE, SH_30, CM_NONE, PO_NONE, dst);
    endfunction

    function automatic t_uop mqc(input t_osel a, input t_osel b, input t_osel c,
                                 input t_cmode cm, input t_raddr dst);
        return u_mul(a, b, c, SH_30, cm, PO_NONE, dst);
    endfunction

    // Micro-program: one shared multiply per step
    function automatic t_uop uop_rom(input t_pc pc);
        t_uop u;
        unique case (pc)
            // reduced latitude to radians, magnitude and square
            7'd0:  u = u_mul(O_RED, cn(CI_D2R), O_NONE, SH_29, CM_NONE, PO_ABS, RG_A);
            7'd1:  u = mq(mr(RG_A), mr(RG_A), RG_X2);
            7'd2:  u = mq(cn(CI_ONE), cn(CI_ONE), RG_T);
            // sine Horner steps
            7'd3:  u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd4:  u = mq(mr(RG_V), cn(CI_MS0), RG_Q);
            7'd5:  u = mqc(mr(RG_Q), cn(CI_DS0), mr(RG_V), CM_DIV, RG_T);
            7'd6:  u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd7:  u = mq(mr(RG_V), cn(CI_MS1), RG_Q);
            7'd8:  u = mqc(mr(RG_Q), cn(CI_DS1), mr(RG_V), CM_DIV, RG_T);
            7'd9:  u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd10: u = mq(mr(RG_V), cn(CI_MS2), RG_Q);
            7'd11: u = mqc(mr(RG_Q), cn(CI_DS2), mr(RG_V), CM_DIV, RG_T);
            7'd12: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd13: u = mq(mr(RG_V), cn(CI_MS3), RG_Q);
            7'd14: u = mqc(mr(RG_Q), cn(CI_DS3), mr(RG_V), CM_DIV, RG_T);
            7'd15: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd16: u = mq(mr(RG_V), cn(CI_MS4), RG_Q);
            7'd17: u = mqc(mr(RG_Q), cn(CI_DS4), mr(RG_V), CM_DIV, RG_T);
            7'd18: u = mq(mr(RG_A), mr(RG_T), RG_S0);
            // cosine Horner steps
            7'd19: u = mq(cn(CI_ONE), cn(CI_ONE), RG_T);
            7'd20: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd21: u = mq(mr(RG_V), cn(CI_MC0), RG_Q);
            7'd22: u = mqc(mr(RG_Q), cn(CI_DC0), mr(RG_V), CM_DIV, RG_T);
            7'd23: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd24: u = mq(mr(RG_V), cn(CI_MC1), RG_Q);
            7'd25: u = mqc(mr(RG_Q), cn(CI_DC1), mr(RG_V), CM_DIV, RG_T);
            7'd26: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd27: u = mq(mr(RG_V), cn(CI_MC2), RG_Q);
            7'd28: u = mqc(mr(RG_Q), cn(CI_DC2), mr(RG_V), CM_DIV, RG_T);
            7'd29: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd30: u = mq(mr(RG_V), cn(CI_MC3), RG_Q);
            7'd31: u = mqc(mr(RG_Q), cn(CI_DC3), mr(RG_V), CM_DIV, RG_T);
            7'd32: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd33: u = mq(mr(RG_V), cn(CI_MC4), RG_Q);
            7'd34: u = mqc(mr(RG_Q), cn(CI_DC4), mr(RG_V), CM_DIV, RG_T);
            7'd35: u = mq(mr(RG_X2), mr(RG_T), RG_V);
            7'd36: u = mq(mr(RG_V), cn(CI_MC5), RG_Q);
            7'd37: u = mqc(mr(RG_Q), cn(CI_DC5), mr(RG_V), CM_DIV, RG_T);
            // quadrant restore and latitude products
            7'd38: u = u_ctl(UK_QSB, RG_SB);
            7'd39: u = u_ctl(UK_QCB, RG_CB);
            7'd40: u = mq(mr(RG_CB), mr(RG_CB), RG_CB2);
            7'd41: u = mq(mr(RG_SB), mr(RG_CB), RG_SC);
            7'd42: u = u_mul(O_DL, cn(CI_D2R), O_NONE, SH_29, CM_NONE, PO_NONE, RG_L);
            7'd43: u = mq(mr(RG_L), mr(RG_L), RG_L2);
            // radius of curvature and meridian series terms
            7'd44: u = mqc(cn(CI_N3), mr(RG_CB2), cn(CI_N2), CM_SUB, RG_P);
            7'd45: u = mqc(mr(RG_P), mr(RG_CB2), cn(CI_N1), CM_SUB, RG_P);
            7'd46: u = u_mul(mr(RG_P), mr(RG_CB2), cn(CI_N0), SH_30, CM_SUB, PO_SHR6,
                             RG_N10);
            7'd47: u = mqc(cn(CI_B3), mr(RG_CB2), cn(CI_B2), CM_SUB, RG_P);
            7'd48: u = mqc(mr(RG_P), mr(RG_CB2), cn(CI_B1), CM_SUB, RG_P);
            7'd49: u = u_mul(mr(RG_P), mr(RG_CB2), cn(CI_B0), SH_30, CM_SUB, PO_SHR6,
                             RG_A0);
            7'd50: u = mqc(cn(CI_A4B), mr(RG_CB2), cn(CI_A4A), CM_ADD, RG_P);
            7'd51: u = mqc(mr(RG_P), mr(RG_CB2), cn(CI_A4C), CM_RSUB, RG_A4);
            7'd52: u = mqc(cn(CI_A6A), mr(RG_CB2), cn(CI_A6B), CM_RSUB, RG_P);
            7'd53: u = mq(mr(RG_P), mr(RG_CB2), RG_A6);
            7'd54: u = mqc(cn(CI_A3B), mr(RG_CB2), cn(CI_A3A), CM_ADD, RG_P);
            7'd55: u = mqc(mr(RG_P), mr(RG_CB2), cn(CI_A3C), CM_RSUB, RG_A3);
            7'd56: u = mqc(cn(CI_A5D), mr(RG_CB2), cn(CI_A5C), CM_ADD, RG_P);
            7'd57: u = mqc(mr(RG_P), mr(RG_CB2), cn(CI_A5B), CM_SUB, RG_P);
            7'd58: u = mqc(mr(RG_P), mr(RG_CB2), cn(CI_A5A), CM_SUB, RG_A5);
            // northing
            7'd59: u = mqc(mr(RG_A6), mr(RG_L2), mr(RG_A4), CM_ADD, RG_P);
            7'd60: u = mqc(mr(RG_P), mr(RG_L2), cn(CI_HALF), CM_ADD, RG_P);
            7'd61: u = mq(mr(RG_P), mr(RG_L2), RG_P);
            7'd62: u = mqc(mr(RG_N10), mr(RG_P), mr(RG_A0), CM_SUB, RG_P);
            7'd63: u = u_mul(O_LAT, cn(CI_K16), O_NONE, SH_29, CM_NONE, PO_NONE, RG_MER);
            7'd64: u = mqc(mr(RG_P), mr(RG_SC), mr(RG_MER), CM_SUB, RG_XO);
            // easting
            7'd65: u = mqc(mr(RG_A5), mr(RG_L2), mr(RG_A3), CM_ADD, RG_P);
            7'd66: u = mqc(mr(RG_P), mr(RG_L2), cn(CI_ONE), CM_ADD, RG_P);
            7'd67: u = mq(mr(RG_P), mr(RG_L), RG_P);
            7'd68: u = mq(mr(RG_N10), mr(RG_P), RG_P);
            7'd69: u = mq(mr(RG_P), mr(RG_CB), RG_YO);
            default: u = u_ctl(UK_END, RG_XO);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

### src/gauss_kruger_local_projection_core.sv
// Top level of the Gauss-Kruger local projection block.
// Projects each accepted fix with the truncated Gauss-Kruger series in its 6-degree zone and
// returns northing and negated easting offsets from the first fix, which is latched as the
// origin (the first result is zero, zero). Offsets are metres in units of 2^-10, saturated to
// +-20480000000. One fix is in flight at a time: its result comes from the 70-step
// micro-program that runs on one shared 36x36 multiplier, each step passing through
// register-file read, multiply and write-back. The next fix is accepted as soon as the
// result sits in the output register, even while it waits to be taken.
`default_nettype none
module gauss_kruger_local_projection_core
    import gkp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    localparam logic signed [41:0] OUT_LIM = 42'sd20480000000;

    logic        r_busy;
    logic        r_start;
    t_prep       r_prep;
    logic        r_out_valid;
    t_out_beat   r_out;
    logic        r_origin_valid;
    logic signed [35:0] r_origin_north, r_origin_east;

    logic        w_accept, w_done, w_take, w_load;
    t_word       w_x, w_y;

    logic signed [32:0] w_lat33, w_sum, w_red;
    logic [1:0]         w_quad;
    logic signed [7:0]  w_h;
    logic [8:0]         w_u;
    logic [16:0]        w_uq;
    logic signed [8:0]  w_z;
    logic signed [10:0] w_z3;
    logic signed [34:0] w_dl;
    logic signed [41:0] w_on, w_oe, w_dn, w_dw;

    function automatic logic signed [35:0] sat36(input logic signed [41:0] v);
        logic signed [41:0] c;
        if (v > OUT_LIM) begin
            c = OUT_LIM;
        end else if (v < -OUT_LIM) begin
            c = -OUT_LIM;
        end else begin
            c = v;
        end
        return c[35:0];
    endfunction

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    // Quadrant reduction of latitude about multiples of 90 degrees
    always_comb begin
        w_lat33 = 33'(i_in_data.latitude);
        w_sum   = w_lat33 + 33'sd377487360;
        priority if (w_sum >= 33'sd754974720) begin
            w_quad = 2'd1;
            w_red  = w_lat33 - 33'sd754974720;
        end else if (w_sum >= 33'sd0) begin
            w_quad = 2'd0;
            w_red  = w_lat33;
        end else if (w_sum >= -33'sd754974720) begin
            w_quad = 2'd3;
            w_red  = w_lat33 + 33'sd754974720;
        end else begin
            w_quad = 2'd2;
            w_red  = w_lat33 + 33'sd1509949440;
        end
    end

    // Zone: floor(lon / 6 deg) = floor(floor(lon / 2^24) / 3), then offset from centre
    always_comb begin
        w_h  = i_in_data.longitude[31:24];
        w_u  = 9'({w_h[7], w_h} + 9'sd129);
        w_uq = 17'(w_u) * 17'd171;
        w_z  = $signed({1'b0, w_uq[16:9]}) - 9'sd43;
        w_z3 = 11'(w_z) * 11'sd3;
        w_dl = 35'(i_in_data.longitude) - {w_z3, 24'b0} - 35'sd25165824;
    end

    // Capture prepared operands on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prep.lat  <= t_word'(i_in_data.latitude);
            r_prep.red  <= t_word'(w_red);
            r_prep.dl   <= t_word'(w_dl);
            r_prep.quad <= w_quad;
        end
    end

    gkp_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_prep  (r_prep),
        .i_take  (w_take),
        .o_done  (w_done),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    assign w_take = !r_out_valid || i_out_ready;
    assign w_load = w_done && w_take;

    // Offsets from the origin; the first fix is its own origin
    always_comb begin
        w_on = r_origin_valid ? 42'(r_origin_north) : 42'(w_x);
        w_oe = r_origin_valid ? 42'(r_origin_east)  : 42'(w_y);
        w_dn = 42'(w_x) - w_on;
        w_dw = w_oe - 42'(w_y);
    end

    // Control: busy flag, start pulse, output beat valid, origin latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_start        <= 1'b0;
            r_out_valid    <= 1'b0;
            r_origin_valid <= 1'b0;
            r_origin_north <= '0;
            r_origin_east  <= '0;
        end else begin
            r_start <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load && !r_origin_valid) begin
                r_origin_valid <= 1'b1;
                r_origin_north <= w_x[35:0];
                r_origin_east  <= w_y[35:0];
            end
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.north_offset <= sat36(w_dn);
            r_out.west_offset  <= sat36(w_dw);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("not busy after accepting a beat");

    a_out_from_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_done))
        else $error("output beat without engine result");

    a_origin_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_origin_valid)
        else $error("result delivered without an origin");

endmodule
`default_nettype wire

### src/gkp_engine.sv
// Micro-sequenced projection engine: register file, shared multiplier, write-back unit.
`default_nettype none
module gkp_engine
    import gkp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_prep i_prep,
    input  wire logic  i_take,
    output logic       o_done,
    output t_word      o_x,
    output t_word      o_y
);

    t_eng_state r_state, n_state;
    t_pc        r_pc, n_pc;
    t_uop       w_uop;

    logic       r_xneg;
    t_word      r_rda, r_rdb;
    t_word      r_opa, r_opb;
    logic signed [PROD_W-1:0] r_prod;

    t_raddr     w_ra, w_rb;
    logic       w_we;
    t_word      w_wd;

    t_word      mem [RF_DEPTH];

    t_word      w_opa, w_opb, w_c, w_pm, w_base, w_rem, w_s0, w_c0, w_qsb, w_qcb;
    logic signed [PROD_W-1:0] w_sh29, w_sh30;
    logic signed [MUL_W-1:0]  w_ma, w_mb;

    function automatic t_word pick(input t_osel s, input t_word memv, input t_prep p);
        t_word v;
        unique case (s.k)
            OK_MEM:  v = memv;
            OK_CON:  v = con_val(s.i);
            OK_LAT:  v = p.lat;
            OK_RED:  v = p.red;
            OK_DL:   v = p.dl;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_uop = uop_rom(r_pc);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        w_ra    = w_uop.a.i[RF_AW-1:0];
        w_rb    = w_uop.b.i[RF_AW-1:0];
        w_we    = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_pc = '0;
                if (i_start) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_uop.kind == UK_END) begin
                    w_ra    = RG_XO;
                    w_rb    = RG_YO;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                w_ra    = w_uop.c.i[RF_AW-1:0];
                n_state = ST_WB;
            end
            ST_WB: begin
                w_we    = 1'b1;
                n_pc    = r_pc + 7'd1;
                n_state = ST_ISSUE;
            end
            ST_OUT: begin
                w_ra   = RG_XO;
                w_rb   = RG_YO;
                o_done = 1'b1;
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Register file: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_uop.dst] <= w_wd;
        end
        r_rda <= mem[w_ra];
        r_rdb <= mem[w_rb];
    end

    // Shared multiplier, operands latched alongside the product
    assign w_opa = pick(w_uop.a, r_rda, i_prep);
    assign w_opb = pick(w_uop.b, r_rdb, i_prep);
    assign w_ma  = w_opa[MUL_W-1:0];
    assign w_mb  = w_opb[MUL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MULT) begin
            r_prod <= w_ma * w_mb;
            r_opa  <= w_opa;
            r_opb  <= w_opb;
        end
    end

    // Write-back: scale, combine, post-process
    always_comb begin
        w_c    = pick(w_uop.c, r_rda, i_prep);
        w_sh29 = r_prod >>> 29;
        w_sh30 = r_prod >>> 30;
        w_pm   = (w_uop.sh == SH_29) ? w_sh29[WORD_W-1:0] : w_sh30[WORD_W-1:0];
        w_rem  = w_c - r_prod[WORD_W-1:0];
        unique case (w_uop.cm)
            CM_NONE: w_base = w_pm;
            CM_ADD:  w_base = w_c + w_pm;
            CM_SUB:  w_base = w_c - w_pm;
            CM_RSUB: w_base = w_pm - w_c;
            CM_DIV:  w_base = ONE_Q30 - (r_opa + ((w_rem >= r_opb) ? 41'sd1 : 41'sd0));
            default: w_base = w_pm;
        endcase

        w_s0 = r_xneg ? -r_opa : r_opa;
        w_c0 = r_opb;
        unique case (i_prep.quad)
            2'd0:    begin w_qsb = w_s0;  w_qcb = w_c0;  end
            2'd1:    begin w_qsb = w_c0;  w_qcb = -w_s0; end
            2'd2:    begin w_qsb = -w_s0; w_qcb = -w_c0; end
            default: begin w_qsb = -w_c0; w_qcb = w_s0;  end
        endcase

        unique case (w_uop.kind)
            UK_QSB:  w_wd = w_qsb;
            UK_QCB:  w_wd = w_qcb;
            default: begin
                unique case (w_uop.po)
                    PO_SHR6: w_wd = w_base >>> 6;
                    PO_ABS:  w_wd = w_base[WORD_W-1] ? -w_base : w_base;
                    default: w_wd = w_base;
                endcase
            end
        endcase
    end

    // Hold the sign of the reduced angle for the sine
    always_ff @(posedge i_clk) begin
        if (w_we && w_uop.kind == UK_MUL && w_uop.po == PO_ABS) begin
            r_xneg <= w_base[WORD_W-1];
        end
    end

    assign o_x = r_rda;
    assign o_y = r_rdb;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == ST_IDLE)
        else $error("engine started while busy");

    a_out_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |-> r_pc == PC_END + 7'd1)
        else $error("result presented before program end");

    a_wb_after_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WB |-> $past(r_state) == ST_MULT)
        else $error("write-back without multiply");

endmodule
`default_nettype wire
